// ===== sv/neighbour_id_dedup_table_core_defines.svh =====
// ---------------------------------------------------------------------------
// Neighbour ID dedup table - assertion macros
// Shared property wrappers for the table core checks.
// ---------------------------------------------------------------------------
`ifndef NEIGHBOUR_ID_DEDUP_TABLE_CORE_DEFINES_SVH
`define NEIGHBOUR_ID_DEDUP_TABLE_CORE_DEFINES_SVH

// Clocked check, off while reset is low.
`define NDT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define NDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/ndt_pkg.sv =====
// ---------------------------------------------------------------------------
// Neighbour ID dedup table - package
// Types and sizing constants shared by the compare cells and the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ndt_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  // count must hold TABLE_DEPTH itself
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned REPORT_W = 6;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic [31:0] low;
    logic [31:0] mid;
    logic [31:0] high;
  } id_t;

  // query word walking down the cell chain
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] rem;   // filled entries still to be compared
    logic             hit;
    id_t              id;
  } query_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] id_low_word;
    logic [31:0] id_mid_word;
    logic [31:0] id_high_word;
  } in_word_t;

  typedef struct packed {
    logic [REPORT_W-1:0] neighbour_count;
    logic                already_present;
    logic                dropped_full;
  } out_word_t;

  // count reported modulo 2^REPORT_W
  function automatic logic [REPORT_W-1:0] to_report(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+REPORT_W-1:0] ext;
    ext = {{REPORT_W{1'b0}}, cnt};
    return ext[REPORT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/neighbour_id_dedup_table_core.sv =====
// ---------------------------------------------------------------------------
// Neighbour ID dedup table - core
// Bounded table of distinct 96-bit identifiers built as a chain of cells.
// ---------------------------------------------------------------------------
// One word in, one word out. An add word walks the chain of TABLE_DEPTH
// compare cells, one cell per cycle, each cell holding one entry; at the
// end of the chain a miss is appended at the fill position (or flagged as
// dropped when the table is full). An add therefore occupies the block
// until its walk of the cell chain ends and its result is passed on; a
// clear word only reports and zeroes the fill count. The result sits in an
// output register, so a new word is taken while an earlier result still
// waits. Entries past the fill count are never compared, so no clearing
// pass is needed after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "neighbour_id_dedup_table_core_defines.svh"

module neighbour_id_dedup_table_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ndt_pkg::in_word_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ndt_pkg::out_word_t     out_data_o
);
  import ndt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  out_word_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_data_q, out_data_d;

  logic             in_accept;
  logic             out_free;
  logic             has_room;
  logic             wr_vld;
  logic [IDX_W-1:0] wr_idx;
  id_t              in_id;
  query_t           chain [0:TABLE_DEPTH];
  query_t           tail;

  // Only accepted from idle; chain and response slot are single-word.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // output register can take a word this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_id.low  = in_data_i.id_low_word;
  assign in_id.mid  = in_data_i.id_mid_word;
  assign in_id.high = in_data_i.id_high_word;

  // Head of the chain: the query carries the fill count so that each
  // cell knows whether its entry is filled.
  assign chain[0] = '{vld: in_accept && (in_data_i.kind == KIND_ADD),
                      rem: count_q,
                      hit: 1'b0,
                      id:  in_id};

  assign tail     = chain[TABLE_DEPTH];
  assign has_room = (count_q < CNT_W'(TABLE_DEPTH));
  // Append a miss at the fill position once the walk is done.
  assign wr_vld   = tail.vld && !tail.hit && has_room;
  assign wr_idx   = count_q[IDX_W-1:0];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    ndt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .query_i (chain[k]),
      .wr_en_i (wr_vld && (wr_idx == IDX_W'(k))),
      .wr_id_i (tail.id),
      .query_o (chain[k+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.kind == KIND_CLEAR) begin
            // report the count held, then empty the table
            res_d.neighbour_count = to_report(count_q);
            res_d.already_present = 1'b0;
            res_d.dropped_full    = 1'b0;
            count_d               = '0;
            state_d               = ST_RESP;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (tail.vld) begin
          res_d.already_present = tail.hit;
          res_d.dropped_full    = !tail.hit && !has_room;
          if (wr_vld) begin
            count_d               = count_q + CNT_W'(1);
            res_d.neighbour_count = to_report(count_q + CNT_W'(1));
          end else begin
            res_d.neighbour_count = to_report(count_q);
          end
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `NDT_ASSERT(a_count_bounded, clk_i, rst_ni, count_q <= CNT_W'(TABLE_DEPTH), "fill count past depth")
  `NDT_ASSERT(a_tail_in_walk, clk_i, rst_ni, tail.vld |-> (state_q == ST_WALK), "query outside walk")
  `NDT_ASSERT(a_flags_exclusive, clk_i, rst_ni, out_valid_o |-> !(out_data_o.already_present && out_data_o.dropped_full), "hit and drop together")
  `NDT_ASSERT(a_clear_empties, clk_i, rst_ni, (in_accept && (in_data_i.kind == KIND_CLEAR)) |=> (count_q == '0), "clear left entries")
  `NDT_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

`default_nettype wire

// ===== sv/ndt_cell.sv =====
// ---------------------------------------------------------------------------
// Neighbour ID dedup table - compare cell
// Holds one table entry; compares the passing query and forwards it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndt_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ndt_pkg::query_t query_i,
  input  wire logic           wr_en_i,
  input  wire ndt_pkg::id_t   wr_id_i,
  output ndt_pkg::query_t     query_o
);
  import ndt_pkg::*;

  id_t    entry_q;
  query_t query_q;
  query_t query_d;
  logic   live;
  logic   match;

  // entry counts only while filled entries remain ahead of this cell
  assign live  = (query_i.rem != '0);
  assign match = query_i.vld && live && (entry_q == query_i.id);

  always_comb begin
    query_d     = query_i;
    query_d.hit = query_i.hit | match;
    query_d.rem = live ? (query_i.rem - CNT_W'(1)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_q <= '0;
    end else begin
      query_q <= query_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_id_i;
    end
  end

  assign query_o = query_q;

endmodule

`default_nettype wire
